/* design/pmst_pkg.sv */
// Shared types and constants for the Prim spanning tree core.
package pmst_pkg;

   localparam int DEFAULT_MAX_VERTICES = 16;
   // Input row and column fields are 4 bits wide, so no more than 16 vertices are addressable.
   localparam int INDEX_LIMIT          = 16;
   localparam int WEIGHT_W             = 16;
   localparam int VERTEX_W             = 5;
   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [3:0]          row_index;
      logic [3:0]          col_index;
      logic [WEIGHT_W-1:0] weight;
      logic                last_entry;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] from_vertex;
      logic [WEIGHT_W-1:0] edge_weight;
      logic [VERTEX_W-1:0] to_vertex;
      logic                disconnected;
      logic                last_edge;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic eligible;
   } track_ctl_type;

endpackage

/* design/prim_mst_adjacency_matrix_core.sv */
// Prim minimum spanning tree core: loads a weight matrix, then emits tree edges from vertex 0.
//
// Matrix entries load one per cycle into the weight memory while the core is idle; a request
// flagged last_entry starts a run over the first n vertices (n from csr vertex_count). Each
// step sweeps all n*n matrix entries through the single read port of the weight memory, one
// per cycle, then drains the read pipeline and posts the edge, waiting while the result
// channel stalls. Requests are refused during a run. No clearing pass follows reset; matrix
// entries must be written before a run reads them. A run on one vertex posts no result; a
// graph with no crossing edge left posts one result flagged disconnected and ends the run.
module prim_mst_adjacency_matrix_core #(
   parameter int MAX_VERTICES = pmst_pkg::DEFAULT_MAX_VERTICES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pmst_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pmst_pkg::rsp_type             rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [pmst_pkg::VERTEX_W-1:0] csr_write_data
);

   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int AW   = 2 * VW;
   localparam int NCAP = (MAX_VERTICES < pmst_pkg::INDEX_LIMIT) ? MAX_VERTICES
                                                                 : pmst_pkg::INDEX_LIMIT;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [pmst_pkg::VERTEX_W-1:0] vertex_count_ff;
   logic [pmst_pkg::VERTEX_W-1:0] n_eff;
   logic [VW-1:0]                 n_last_ff, n_last_in;
   logic [VW-1:0]                 row_ff, row_in;
   logic [VW-1:0]                 col_ff, col_in;
   logic [VW-1:0]                 edges_ff, edges_in;
   logic [MAX_VERTICES-1:0]       visited_ff, visited_in;
   logic                          rd_valid_ff;
   logic [VW-1:0]                 rd_row_ff, rd_col_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   pmst_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_load;

   logic                          req_accept;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic                          rd_en;
   logic [pmst_pkg::WEIGHT_W-1:0] rd_data;

   pmst_pkg::track_ctl_type       track_ctl;
   logic                          track_clear;
   logic                          found;
   logic [pmst_pkg::WEIGHT_W-1:0] best_weight;
   logic [VW-1:0]                 best_row;
   logic [VW-1:0]                 best_col;
   logic                          rsp_free;
   logic                          final_edge;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Entries beyond the store are dropped.
   assign wr_en   = req_accept && (int'(req_payload.row_index) < MAX_VERTICES) &&
                    (int'(req_payload.col_index) < MAX_VERTICES);
   assign wr_addr = {VW'(req_payload.row_index), VW'(req_payload.col_index)};
   assign rd_en   = (state_ff == ST_SCAN);

   always_comb begin
      if (vertex_count_ff == '0) begin
         n_eff = pmst_pkg::VERTEX_W'(1);
      end else if (int'(vertex_count_ff) > NCAP) begin
         n_eff = pmst_pkg::VERTEX_W'(NCAP);
      end else begin
         n_eff = vertex_count_ff;
      end
   end

   assign final_edge = (VW'(edges_ff + 1'b1) == n_last_ff);

   pmst_weight_ram #(
      .ADDR_W (AW),
      .DATA_W (pmst_pkg::WEIGHT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.weight),
      .rd_en   (rd_en),
      .rd_addr ({row_ff, col_ff}),
      .rd_data (rd_data)
   );

   assign track_ctl = '{clear:    track_clear,
                        sample:   rd_valid_ff,
                        eligible: visited_ff[rd_row_ff] && !visited_ff[rd_col_ff]};

   pmst_min_track #(
      .VW (VW)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .ctl         (track_ctl),
      .data        (rd_data),
      .tag_row     (rd_row_ff),
      .tag_col     (rd_col_ff),
      .found       (found),
      .best_weight (best_weight),
      .best_row    (best_row),
      .best_col    (best_col)
   );

   always_comb begin
      state_in     = state_ff;
      n_last_in    = n_last_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      edges_in     = edges_ff;
      visited_in   = visited_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      track_clear  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_payload.last_entry) begin
               n_last_in = VW'(n_eff - 1'b1);
               // A single vertex run posts nothing.
               if (n_eff != pmst_pkg::VERTEX_W'(1)) begin
                  visited_in  = MAX_VERTICES'(1);
                  edges_in    = '0;
                  row_in      = '0;
                  col_in      = '0;
                  track_clear = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (col_ff == n_last_ff) begin
               col_in = '0;
               if (row_ff == n_last_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (!found) begin
                  rsp_in.from_vertex  = '0;
                  rsp_in.edge_weight  = '0;
                  rsp_in.to_vertex    = '0;
                  rsp_in.disconnected = 1'b1;
                  rsp_in.last_edge    = 1'b1;
                  state_in            = ST_IDLE;
               end else begin
                  rsp_in.from_vertex  = pmst_pkg::VERTEX_W'(best_row) + 1'b1;
                  rsp_in.edge_weight  = best_weight;
                  rsp_in.to_vertex    = pmst_pkg::VERTEX_W'(best_col) + 1'b1;
                  rsp_in.disconnected = 1'b0;
                  rsp_in.last_edge    = final_edge;
                  visited_in[best_col] = 1'b1;
                  edges_in            = edges_ff + 1'b1;
                  if (final_edge) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in      = '0;
                     col_in      = '0;
                     track_clear = 1'b1;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= pmst_pkg::VERTEX_COUNT_RESET;
         visited_ff      <= '0;
         edges_ff        <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         n_last_ff       <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         edges_ff     <= edges_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         n_last_ff    <= n_last_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            vertex_count_ff <= csr_write_data;
         end
      end
   end

   // Tag each read with its matrix position, registered from the address so it lines up with the read data.
   always_ff @(posedge clock) begin
      rd_row_ff <= row_ff;
      rd_col_ff <= col_ff;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/pmst_weight_ram.sv */
// Single write port, single registered read port weight memory.
module pmst_weight_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pmst_min_track.sv */
// Running minimum of crossing-edge weights over one scan of the matrix.
module pmst_min_track #(
   parameter int VW = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pmst_pkg::track_ctl_type       ctl,
   input  logic [pmst_pkg::WEIGHT_W-1:0] data,
   input  logic [VW-1:0]                 tag_row,
   input  logic [VW-1:0]                 tag_col,
   output logic                          found,
   output logic [pmst_pkg::WEIGHT_W-1:0] best_weight,
   output logic [VW-1:0]                 best_row,
   output logic [VW-1:0]                 best_col
);

   logic                          found_ff;
   logic [pmst_pkg::WEIGHT_W-1:0] best_weight_ff;
   logic [VW-1:0]                 best_row_ff;
   logic [VW-1:0]                 best_col_ff;
   logic                          take;

   // Strict less-than keeps the first candidate on equal weights.
   assign take = ctl.sample && ctl.eligible && (data != '0) &&
                 (!found_ff || (data < best_weight_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctl.clear) begin
         best_weight_ff <= data;
         best_row_ff    <= tag_row;
         best_col_ff    <= tag_col;
      end
   end

   assign found       = found_ff;
   assign best_weight = best_weight_ff;
   assign best_row    = best_row_ff;
   assign best_col    = best_col_ff;

endmodule
